// ===== rtl/core/ternary_fingering_match_table_unit_defines.svh =====
// Assertion macros for the ternary fingering match table unit.
// Taken in by the top level only; no other dependencies.
`ifndef TERNARY_FINGERING_MATCH_TABLE_UNIT_DEFINES_SVH
`define TERNARY_FINGERING_MATCH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfm assertion failed");

// Next-cycle implication, disabled while in reset.
`define TFM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfm assertion failed");

`endif

// ===== rtl/core/tfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the ternary fingering match table.
// No dependencies.
package tfm_pkg;

    localparam int ENTRIES       = 16;
    localparam int IDX_W         = $clog2(ENTRIES);
    localparam int HOLES         = 9;
    localparam int PATTERN_BYTES = 5;
    localparam int HOLE_K_W      = $clog2(PATTERN_BYTES);

    localparam int IN_BITS   = 8 + HOLES;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COVERED_CODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THRESHOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DONT_CARE_CODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PACKET_ID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_PACKET_ID = 3'd4;

    // action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [7:0] DONT_CARE_RESET = 8'h0F;

    typedef struct packed {
        logic [3:0] covered_code;
        logic [3:0] open_threshold;
        logic [7:0] dont_care_code;
    } tfm_match_cfg_t;

    // write request broadcast along the row of cells
    typedef struct packed {
        logic                clear;
        logic [7:0]          fill;
        logic                note_we;
        logic                hole_we;
        logic                hole_or;
        logic [HOLE_K_W-1:0] hole_k;
        logic [IDX_W-1:0]    slot;
        logic [7:0]          data;
    } tfm_wr_t;

    // lookup token that walks the row one cell per cycle
    typedef struct packed {
        logic             valid;
        logic [HOLES-1:0] pattern;
        logic             found;
        logic [7:0]       note;
    } tfm_query_t;

    typedef struct packed {
        logic       table_enabled;
        logic       matched;
        logic [7:0] note;
    } tfm_result_t;

endpackage

// ===== rtl/core/ternary_fingering_match_table_unit.sv =====
`timescale 1ns / 1ps
// Ternary fingering match table, first-hit priority, as a row of ENTRIES cells.
// A load transfer may be followed by another transfer in the next cycle.
// Lookup transfer: the token passes through the ENTRIES cell registers and
// then the output register before m_tvalid rises; no next transfer is
// accepted until the result has left the row and the skid stage is empty.
// rst_n is asynchronous, active low; the table is in its cleared state at once.
// Depends on tfm_pkg, tfm_cell, tfm_loader and the defines header.
`include "ternary_fingering_match_table_unit_defines.svh"

module ternary_fingering_match_table_unit
    import tfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] packet_byte, [16:8] sensor_pattern
    input  logic                 s_tuser,   // [0] action
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] note
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] matched, [1] table_enabled
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0] covered_code_reg;
    logic [3:0] open_threshold_reg;
    logic [7:0] dont_care_code_reg;
    logic [7:0] start_packet_id_reg;
    logic [7:0] pattern_packet_id_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            covered_code_reg      <= 4'd1;
            open_threshold_reg    <= 4'd2;
            dont_care_code_reg    <= DONT_CARE_RESET;
            start_packet_id_reg   <= 8'd0;
            pattern_packet_id_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COVERED_CODE:      covered_code_reg      <= cfg_data[3:0];
                CFG_OPEN_THRESHOLD:    open_threshold_reg    <= cfg_data[3:0];
                CFG_DONT_CARE_CODE:    dont_care_code_reg    <= cfg_data;
                CFG_START_PACKET_ID:   start_packet_id_reg   <= cfg_data;
                CFG_PATTERN_PACKET_ID: pattern_packet_id_reg <= cfg_data;
                default: ;   // unused indexes are dropped
            endcase
        end
    end

    tfm_match_cfg_t match_cfg;
    assign match_cfg.covered_code   = covered_code_reg;
    assign match_cfg.open_threshold = open_threshold_reg;
    assign match_cfg.dont_care_code = dont_care_code_reg;

    // ------------------------------------------------------------------
    // Input side. The input stream stalls while a lookup walks the row, so
    // the cells and the entry count are frozen for it. The skid stage lets one
    // finished result wait behind a stalled output; no transfer is taken while it waits.
    // ------------------------------------------------------------------
    logic       busy_reg;
    logic       skid_valid_reg;
    logic       s_fire;
    logic       load_fire;
    logic       lookup_fire;

    assign s_tready    = !busy_reg && !skid_valid_reg;
    assign s_fire      = s_tvalid && s_tready;
    assign load_fire   = s_fire && (s_tuser == ACT_LOAD);
    assign lookup_fire = s_fire && (s_tuser == ACT_LOOKUP);

    // ------------------------------------------------------------------
    // Packet parser
    // ------------------------------------------------------------------
    tfm_wr_t          wr;
    logic [IDX_W-1:0] entry_count;

    tfm_loader u_loader (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_fire   (load_fire),
        .packet_byte (s_tdata[7:0]),
        .start_id    (start_packet_id_reg),
        .pattern_id  (pattern_packet_id_reg),
        .dont_care   (dont_care_code_reg),
        .wr          (wr),
        .entry_count (entry_count)
    );

    // ------------------------------------------------------------------
    // Row of cells: cell i holds entry i. The lookup token enters cell 0
    // on acceptance; the first searchable cell that agrees marks it found
    // and later cells pass it on untouched.
    // ------------------------------------------------------------------
    tfm_query_t q_link [ENTRIES+1];

    always_comb
    begin
        q_link[0]         = '0;
        q_link[0].valid   = lookup_fire;
        q_link[0].pattern = s_tdata[8 +: HOLES];
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        tfm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_id     (IDX_W'(i)),
            .entry_count (entry_count),
            .match_cfg   (match_cfg),
            .wr          (wr),
            .q_in        (q_link[i]),
            .q_out       (q_link[i+1])
        );
    end

    logic        res_valid;
    tfm_result_t res;

    assign res_valid         = q_link[ENTRIES].valid;
    assign res.note          = q_link[ENTRIES].note;
    assign res.matched       = q_link[ENTRIES].found;
    assign res.table_enabled = (entry_count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (lookup_fire)
            busy_reg <= 1'b1;
        else if (res_valid)
            busy_reg <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Output register plus skid stage
    // ------------------------------------------------------------------
    logic        out_valid_reg;
    tfm_result_t out_reg;
    tfm_result_t skid_reg;
    logic        m_fire;

    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= res_valid;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (res_valid)
                    skid_reg <= res;
            end
            else if (res_valid)
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.note;
    assign m_tuser  = {out_reg.table_enabled, out_reg.matched};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // each result leaving the row is an accepted lookup delayed through every cell register
    `TFM_ASSERT_IMP(a_res_timing, clk, rst_n, res_valid, $past(lookup_fire, ENTRIES))
    // the row only produces while a lookup is outstanding
    `TFM_ASSERT_IMP(a_res_busy, clk, rst_n, res_valid, busy_reg)
    // skid holds data only behind a full output register
    `TFM_ASSERT_IMP(a_skid_order, clk, rst_n, skid_valid_reg, out_valid_reg)
    // table size frozen while a lookup walks the row
    `TFM_ASSERT_NXT(a_count_frozen, clk, rst_n, busy_reg, $stable(entry_count))

endmodule

// ===== rtl/core/tfm_cell.sv =====
`timescale 1ns / 1ps
// One table entry: hole codes, note byte, and one stage of the lookup row.
// Depends on tfm_pkg.
module tfm_cell
    import tfm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [IDX_W-1:0] cell_id,
    input  logic [IDX_W-1:0] entry_count,
    input  tfm_match_cfg_t match_cfg,
    input  tfm_wr_t        wr,
    input  tfm_query_t     q_in,
    output tfm_query_t     q_out
);

    logic [7:0] hole_reg [PATTERN_BYTES];
    logic [7:0] note_reg;
    tfm_query_t q_reg;
    tfm_query_t q_next;
    logic       agrees;
    logic       hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < PATTERN_BYTES; b++)
            begin
                hole_reg[b] <= DONT_CARE_RESET;
            end
            note_reg <= 8'd0;
        end
        else if (wr.clear)
        begin
            for (int b = 0; b < PATTERN_BYTES; b++)
            begin
                hole_reg[b] <= wr.fill;
            end
            note_reg <= 8'd0;
        end
        else if (wr.slot == cell_id)
        begin
            if (wr.note_we)
            begin
                note_reg <= wr.data;
            end
            if (wr.hole_we)
            begin
                if (wr.hole_or)
                    hole_reg[wr.hole_k] <= hole_reg[wr.hole_k] | {wr.data[3:0], 4'h0};
                else
                    hole_reg[wr.hole_k] <= wr.data;
            end
        end
    end

    // hole j: byte j/2, low nibble for even j; pattern bit HOLES-1-j
    always_comb
    begin
        logic [3:0] code;
        logic       covered;
        agrees = 1'b1;
        for (int j = 0; j < HOLES; j++)
        begin
            code    = j[0] ? hole_reg[j >> 1][7:4] : hole_reg[j >> 1][3:0];
            covered = q_in.pattern[HOLES-1-j];
            if ({4'h0, code} != match_cfg.dont_care_code)
            begin
                if (!((covered && code == match_cfg.covered_code) ||
                      (!covered && code >= match_cfg.open_threshold)))
                    agrees = 1'b0;
            end
        end
    end

    assign hit = (cell_id < entry_count) && agrees && !q_in.found;

    always_comb
    begin
        q_next       = q_in;
        q_next.found = q_in.found | hit;
        q_next.note  = hit ? note_reg : q_in.note;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else
            q_reg <= q_next;
    end

    assign q_out = q_reg;

endmodule

// ===== rtl/core/tfm_loader.sv =====
`timescale 1ns / 1ps
// Packet stream parser: tracks length, byte index, packet id and entry count,
// and issues write requests to the cells. Depends on tfm_pkg.
module tfm_loader
    import tfm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_fire,
    input  logic [7:0]       packet_byte,
    input  logic [7:0]       start_id,
    input  logic [7:0]       pattern_id,
    input  logic [7:0]       dont_care,
    output tfm_wr_t          wr,
    output logic [IDX_W-1:0] entry_count
);

    localparam logic [7:0] BI_ID      = 8'd0;
    localparam logic [7:0] BI_NOTE    = 8'd1;
    localparam logic [7:0] BI_CTRL    = 8'd2;
    localparam logic [7:0] BI_PAYLOAD = 8'd3;

    logic [7:0]       pkt_len_reg, pkt_len_next;
    logic [7:0]       bi_reg, bi_next;
    logic [7:0]       cur_id_reg, cur_id_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [7:0]       bi_inc;
    logic [7:0]       off;
    logic [6:0]       k_full;
    logic             clear_hit;

    assign bi_inc = bi_reg + 8'd1;
    assign off    = bi_reg - BI_PAYLOAD;
    assign k_full = off[7:1];

    always_comb
    begin
        pkt_len_next = pkt_len_reg;
        bi_next      = bi_reg;
        cur_id_next  = cur_id_reg;
        count_next   = count_reg;
        clear_hit    = 1'b0;
        wr           = '0;
        wr.fill      = dont_care;
        wr.slot      = count_reg;
        wr.data      = packet_byte;
        wr.hole_k    = k_full[HOLE_K_W-1:0];
        if (load_fire)
        begin
            if (pkt_len_reg == 8'd0)
            begin
                pkt_len_next = packet_byte;
                bi_next      = 8'd0;
            end
            else
            begin
                unique case (bi_reg)
                    BI_ID:
                    begin
                        cur_id_next = packet_byte;
                        clear_hit   = (packet_byte == start_id);
                    end
                    BI_NOTE: wr.note_we = 1'b1;
                    BI_CTRL: ;
                    default:
                    begin
                        if (cur_id_reg == pattern_id && k_full < 7'(PATTERN_BYTES))
                        begin
                            wr.hole_we = 1'b1;
                            wr.hole_or = !bi_reg[0];
                        end
                    end
                endcase
                if (clear_hit)
                begin
                    // start packet: table wiped, next byte is a length again
                    wr.clear     = 1'b1;
                    count_next   = '0;
                    pkt_len_next = 8'd0;
                    cur_id_next  = 8'd0;
                    bi_next      = 8'd1;
                end
                else
                begin
                    bi_next = bi_inc;
                    if (bi_inc == pkt_len_reg)
                    begin
                        pkt_len_next = 8'd0;
                        if (count_reg != IDX_W'(ENTRIES - 1))
                            count_next = count_reg + IDX_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_len_reg <= 8'd0;
            bi_reg      <= 8'd0;
            cur_id_reg  <= 8'd0;
            count_reg   <= '0;
        end
        else
        begin
            pkt_len_reg <= pkt_len_next;
            bi_reg      <= bi_next;
            cur_id_reg  <= cur_id_next;
            count_reg   <= count_next;
        end
    end

    assign entry_count = count_reg;

endmodule
